// ===== rtl/avg_pkg.sv =====
// ----------------------------------------------------------------------------
// avg_pkg
// Shared types, constants and tables for the arc vertex generator.
// ----------------------------------------------------------------------------
package avg_pkg;

    // Number of rotation steps in the CORDIC unit.
    localparam int CORDIC_STEPS = 16;
    // Largest number of segments per full turn.
    localparam int MAX_SUBDIV = 62;
    // Width of the shared step counter (division and rotation).
    localparam int ITER_W = 5;
    // Steps of the restoring division of one turn by the segment count.
    localparam int DIV_STEPS = 17;

    localparam logic [16:0] FULL_TURN = 17'h10000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ANGLE_START  = 3'd0,
        REG_ANGLE_END    = 3'd1,
        REG_SUBDIV       = 3'd2,
        REG_INTER_ONLY   = 3'd3,
        REG_FILL_MODE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        circle_radius;
    } t_circle;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [5:0]         vertex_index;
        logic               triangle_valid;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic [16:0] angle_start;
        logic [16:0] angle_end;
        logic [5:0]  subdivisions;
        logic        intermediate_only;
        logic        fill_mode;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_item;
        logic              div_step;
        logic              loop_init;
        logic              emit_center;
        logic              rot_init;
        logic              sel_end;
        logic              rot_step;
        logic [ITER_W-1:0] iter;
        logic              mul1;
        logic              mul2;
        logic              emit_arc;
        logic              last;
        logic              advance;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic i_lt_n;
        logic i_next_ge_n;
    } t_dp_stat;

    // Arc tangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [33:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic signed [33:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10679838;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670163;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                5'd24: v = 34'sd41;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/avg_ctrl.sv =====
// ----------------------------------------------------------------------------
// avg_ctrl
// Sequencer for one circle: setup division, center vertex in fill mode,
// then one CORDIC rotation and two multiplies per arc vertex.
// ----------------------------------------------------------------------------
module avg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  avg_pkg::t_cfg     i_cfg,
    input  avg_pkg::t_dp_stat i_stat,
    output avg_pkg::t_dp_cmd  o_cmd
);
    import avg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_INIT   = 9'b000000100,
        S_CENTER = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_ROT    = 9'b000100000,
        S_MUL1   = 9'b001000000,
        S_MUL2   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_end, n_end;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_end   = r_end;
        o_cmd   = '0;
        o_cmd.iter = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.loop_init = 1'b1;
                n_state = i_cfg.fill_mode ? S_CENTER : S_CHECK;
            end
            S_CENTER: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_center = 1'b1;
                    o_cmd.last = i_cfg.intermediate_only && !i_stat.i_lt_n;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_stat.i_lt_n) begin
                    o_cmd.rot_init = 1'b1;
                    n_end   = 1'b0;
                    n_state = S_ROT;
                end else if (!i_cfg.intermediate_only) begin
                    o_cmd.rot_init = 1'b1;
                    o_cmd.sel_end  = 1'b1;
                    n_end   = 1'b1;
                    n_state = S_ROT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_arc = 1'b1;
                    o_cmd.last = r_end ||
                                 (i_cfg.intermediate_only && i_stat.i_next_ge_n);
                    if (r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_end   <= n_end;
        end
    end

endmodule

// ===== rtl/avg_dp.sv =====
// ----------------------------------------------------------------------------
// avg_dp
// Datapath: setup arithmetic, restoring divider for the angle step, iterative
// CORDIC rotation, radius multiply with rounding and saturation, output stage.
// ----------------------------------------------------------------------------
module avg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  avg_pkg::t_cfg     i_cfg,
    input  avg_pkg::t_circle  i_in_item,
    input  avg_pkg::t_dp_cmd  i_cmd,
    output avg_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output avg_pkg::t_vertex  o_out_item
);
    import avg_pkg::*;

    // Item and setup registers.
    logic signed [31:0] r_cx, r_cy;
    logic [30:0]        r_rad;
    logic [16:0]        r_st, r_en;
    logic [5:0]         r_sd, r_n;
    logic [5:0]         r_rem;
    logic [16:0]        r_quo;
    logic [5:0]         r_i, r_off_r;
    logic [16:0]        r_off_q;
    logic [5:0]         r_k;
    // Rotation and multiply registers.
    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0]         r_quad;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_vx;
    // Output stage.
    logic               r_out_valid;
    t_vertex            r_out;

    // Setup values from the configuration.
    logic [16:0] st_sat, en_sat, diff;
    logic [5:0]  sd_clamp;
    logic [22:0] span;
    logic [23:0] span_up;
    always_comb begin
        st_sat = (i_cfg.angle_start > FULL_TURN) ? FULL_TURN : i_cfg.angle_start;
        en_sat = (i_cfg.angle_end > FULL_TURN) ? FULL_TURN : i_cfg.angle_end;
        if (i_cfg.subdivisions == 6'd0) begin
            sd_clamp = 6'd1;
        end else if (i_cfg.subdivisions > 6'(MAX_SUBDIV)) begin
            sd_clamp = 6'(MAX_SUBDIV);
        end else begin
            sd_clamp = i_cfg.subdivisions;
        end
        diff    = (en_sat > st_sat) ? (en_sat - st_sat) : 17'd0;
        span    = diff * sd_clamp;
        span_up = {1'b0, span} + 24'd65535;
    end

    // One restoring division step on one turn (a one followed by zeros).
    logic [6:0] div_t;
    logic       div_ge;
    always_comb begin
        div_t  = {r_rem, (i_cmd.iter == '0)};
        div_ge = (div_t >= {1'b0, r_sd});
    end

    // Loop advance: offset grows by quotient and remainder of the step.
    logic [6:0] adv_r;
    logic       adv_c;
    always_comb begin
        adv_r = {1'b0, r_off_r} + {1'b0, r_rem};
        adv_c = (adv_r >= {1'b0, r_sd});
    end

    // Angle of the next vertex, modulo one turn.
    logic [15:0] angle;
    assign angle = i_cmd.sel_end ? r_en[15:0] : (r_st[15:0] + r_off_q[15:0]);

    // One CORDIC step.
    logic signed [33:0] x_sh, y_sh, atan_v;
    assign x_sh   = r_x >>> i_cmd.iter;
    assign y_sh   = r_y >>> i_cmd.iter;
    assign atan_v = atan_turn(i_cmd.iter);

    // Clamp and quadrant mapping.
    logic signed [33:0] xc, yc;
    logic signed [31:0] cos_v, sin_v;
    always_comb begin
        xc = (r_x > ONE_Q30) ? ONE_Q30 : ((r_x < -ONE_Q30) ? -ONE_Q30 : r_x);
        yc = (r_y > ONE_Q30) ? ONE_Q30 : ((r_y < -ONE_Q30) ? -ONE_Q30 : r_y);
        case (r_quad)
            2'd0: begin cos_v = xc[31:0];         sin_v = yc[31:0];         end
            2'd1: begin cos_v = 32'(-yc);         sin_v = xc[31:0];         end
            2'd2: begin cos_v = 32'(-xc);         sin_v = 32'(-yc);         end
            default: begin cos_v = yc[31:0];      sin_v = 32'(-xc);         end
        endcase
    end

    // Radius times unit vector, rounded, plus the center, saturated.
    function automatic logic signed [31:0] place(input logic signed [63:0] p,
                                                 input logic signed [31:0] c);
        logic signed [63:0] pr;
        logic signed [34:0] s;
        begin
            pr = p + 64'sd536870912;
            s  = 35'($signed(pr[63:30])) + 35'(c);
            if (s > 35'sd2147483647) begin
                return 32'h7FFFFFFF;
            end else if (s < -35'sd2147483648) begin
                return 32'h80000000;
            end
            return s[31:0];
        end
    endfunction

    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    assign mul_b = i_cmd.mul1 ? cos_v : sin_v;
    assign mul_p = $signed({1'b0, r_rad}) * mul_b;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cx  <= i_in_item.center_x;
            r_cy  <= i_in_item.center_y;
            r_rad <= i_in_item.circle_radius;
            r_st  <= st_sat;
            r_en  <= en_sat;
            r_sd  <= sd_clamp;
            r_n   <= span_up[21:16];
            r_rem <= '0;
            r_quo <= '0;
            r_k   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 6'(div_t - {1'b0, r_sd}) : div_t[5:0];
            r_quo <= {r_quo[15:0], div_ge};
        end
        if (i_cmd.loop_init) begin
            if (i_cfg.intermediate_only) begin
                r_i     <= 6'd1;
                r_off_q <= r_quo;
                r_off_r <= r_rem;
            end else begin
                r_i     <= '0;
                r_off_q <= '0;
                r_off_r <= '0;
            end
        end
        if (i_cmd.advance) begin
            r_i     <= r_i + 1'b1;
            r_off_r <= adv_c ? 6'(adv_r - {1'b0, r_sd}) : adv_r[5:0];
            r_off_q <= r_off_q + r_quo + {16'd0, adv_c};
        end
        if (i_cmd.emit_center || i_cmd.emit_arc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.rot_init) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {4'd0, angle[13:0], 16'd0};
            r_quad <= angle[15:14];
        end
        if (i_cmd.rot_step) begin
            if (!r_z[33]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
        if (i_cmd.mul1) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul2) begin
            r_vx   <= place(r_prod, r_cx);
            r_prod <= mul_p;
        end
        if (i_cmd.emit_center) begin
            r_out.vertex_x <= r_cx;
            r_out.vertex_y <= r_cy;
        end
        if (i_cmd.emit_arc) begin
            r_out.vertex_x <= r_vx;
            r_out.vertex_y <= place(r_prod, r_cy);
        end
        if (i_cmd.emit_center || i_cmd.emit_arc) begin
            r_out.vertex_index   <= r_k;
            r_out.triangle_valid <= i_cfg.fill_mode && (r_k >= 6'd2);
            r_out.last_vertex    <= i_cmd.last;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_center || i_cmd.emit_arc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_stat.i_lt_n      = (r_i < r_n);
    assign o_stat.i_next_ge_n = ({1'b0, r_i} + 7'd1) >= {1'b0, r_n};

endmodule

// ===== rtl/arc_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// arc_vertex_generator
// Tessellates one circular arc per item into a vertex list (fan or contour).
// ----------------------------------------------------------------------------
// Sequence: setup division, the center vertex in fill mode, then for each
// arc vertex a 16-step iterative CORDIC, two radius multiplies and emit.
// One circle at a time; each emit waits until the output register is free.
// Reset: synchronous active low; clears the sequencer, the output valid and
// loads the configuration defaults.
// ----------------------------------------------------------------------------
module arc_vertex_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  avg_pkg::t_circle  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output avg_pkg::t_vertex  o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [16:0]       i_cfg_data
);
    import avg_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start       <= '0;
            r_cfg.angle_end         <= FULL_TURN;
            r_cfg.subdivisions      <= 6'd20;
            r_cfg.intermediate_only <= 1'b0;
            r_cfg.fill_mode         <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ANGLE_START: r_cfg.angle_start       <= i_cfg_data;
                REG_ANGLE_END:   r_cfg.angle_end         <= i_cfg_data;
                REG_SUBDIV:      r_cfg.subdivisions      <= i_cfg_data[5:0];
                REG_INTER_ONLY:  r_cfg.intermediate_only <= i_cfg_data[0];
                REG_FILL_MODE:   r_cfg.fill_mode         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    avg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg      (r_cfg),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    avg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // A fan triangle never closes before the third vertex.
    a_tri_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.triangle_valid) |-> (o_out_item.vertex_index >= 6'd2))
        else $error("triangle flagged on an early vertex");

    // A circle is taken only when the sequencer is idle, so ready drops after it.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while a circle is in progress");

    // Contour mode never flags triangles.
    a_contour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_cfg.fill_mode && $stable(r_cfg.fill_mode)
         && $rose(o_out_valid)) |-> !o_out_item.triangle_valid)
        else $error("triangle flagged in contour mode");

endmodule
